>>> design/rwra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rwra_pkg;

  // Field widths
  localparam int LEN_W       = 32;
  localparam int TIME_SLOT_W = 2;
  localparam int PCT_W       = 7;
  localparam int LOG_W       = 7;
  localparam int CNT_W       = 64;
  localparam int LEAD_W      = 6;
  localparam int PCT_SUM_W   = 10;

  // Advice constants
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd70;
  localparam int               PCT_MAX   = 90;
  localparam int               PCT_MIN   = 50;

  typedef logic [CNT_W-1:0] cnt_t;

  // Command to the slot counter bank for one beat
  typedef struct packed {
    logic en;
    logic clear;
    logic is_read;
  } bank_cmd_t;

  // Advice status formed from the counter bank
  typedef struct packed {
    logic                    many_empty;
    logic signed [LOG_W-1:0] log_ratio;
    logic [PCT_W-1:0]        percent;
  } advice_t;

  // Add two counters, stick at all ones on overflow
  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Position of the leading one, zero for zero
  function automatic logic [LEAD_W-1:0] lead_one(input cnt_t v);
    logic [LEAD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = LEAD_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/rwra_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Access beat channel
interface rwra_in_if;
  logic                              valid;
  logic                              ready;
  logic [rwra_pkg::LEN_W-1:0]        access_length;
  logic                              is_read;
  logic [rwra_pkg::TIME_SLOT_W-1:0]  time_slot;

  modport source (output valid, access_length, is_read, time_slot, input ready);
  modport sink   (input valid, access_length, is_read, time_slot, output ready);
endinterface

// Advice beat channel
interface rwra_out_if;
  logic                               valid;
  logic                               ready;
  logic [rwra_pkg::PCT_W-1:0]         pmem_percent;
  logic signed [rwra_pkg::LOG_W-1:0]  log_ratio;
  logic                               advice_updated;

  modport source (output valid, pmem_percent, log_ratio, advice_updated, input ready);
  modport sink   (input valid, pmem_percent, log_ratio, advice_updated, output ready);
endinterface

// Configuration write channel
interface rwra_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rwra_pkg::PCT_W-1:0]  base_percent;

  modport source (output valid, base_percent, input ready);
  modport sink   (input valid, base_percent, output ready);
endinterface
`default_nettype wire

>>> design/read_write_ratio_advisor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Read/write ratio advisor.
// in_i carries one access beat (length, read flag, low bits of the second).
// Bytes are counted per slot in a ring of SLOT_COUNT saturating 64-bit
// counters; when the slot changes, advice is formed from all slots before
// the new slot is cleared and the access counted.
// out_o returns one beat per access: the held percent, the held log ratio
// and a flag telling whether this access recomputed them.
// cfg_i writes base_percent; it is always ready and only affects later
// recomputations.
// The access beat enters the input register on acceptance and moves to
// the result register, which drives out_o.valid, once out_o is empty or
// ready. Throughput: one access per cycle while out_o does not stall,
// set by the adder tree and leading-one detect between the two registers.
// Reset: counters and current slot clear, percent goes to 70, ratio to 0.
// When out_o stalls, the result register holds, the input register fills,
// and in_i drops ready once both are occupied.
module read_write_ratio_advisor_core #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rwra_cfg_if.sink    cfg_i,
  rwra_in_if.sink     in_i,
  rwra_out_if.source  out_o
);
  import rwra_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [PCT_W-1:0]        base_q;
  logic                    in_valid_q;
  logic [LEN_W-1:0]        len_q;
  logic                    rd_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SLOT_W-1:0]       slot_d;
  logic [SLOT_W-1:0]       cur_slot_q;
  logic                    out_valid_q;
  logic [PCT_W-1:0]        pct_q;
  logic signed [LOG_W-1:0] log_q;
  logic                    upd_q;
  logic                    advance;
  logic                    change;
  logic                    upd;
  bank_cmd_t               bank_cmd;
  advice_t                 advice;
  cnt_t                    rd_cnt [SLOT_COUNT];
  cnt_t                    wr_cnt [SLOT_COUNT];

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= PCT_RESET;
    end else if (cfg_i.valid) begin
      base_q <= cfg_i.base_percent;
    end
  end

  // Reduce the time slot into the ring
  always_comb begin
    if (32'(in_i.time_slot) >= SLOT_COUNT) begin
      slot_d = SLOT_W'(32'(in_i.time_slot) - SLOT_COUNT);
    end else begin
      slot_d = SLOT_W'(in_i.time_slot);
    end
  end

  // Input register
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      len_q  <= in_i.access_length;
      rd_q   <= in_i.is_read;
      slot_q <= slot_d;
    end
  end

  // Slot counters and advice
  assign change = slot_q != cur_slot_q;
  assign upd    = change && !advice.many_empty;

  always_comb begin
    bank_cmd.en      = advance;
    bank_cmd.clear   = change;
    bank_cmd.is_read = rd_q;
  end

  rwra_slot_bank #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (bank_cmd),
    .slot_i   (slot_q),
    .len_i    (len_q),
    .rd_cnt_o (rd_cnt),
    .wr_cnt_o (wr_cnt)
  );

  rwra_advice #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_advice (
    .rd_cnt_i (rd_cnt),
    .wr_cnt_i (wr_cnt),
    .base_i   (base_q),
    .advice_o (advice)
  );

  // Result register; held advice doubles as the output payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      pct_q       <= PCT_RESET;
      log_q       <= '0;
      upd_q       <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        cur_slot_q  <= slot_q;
        upd_q       <= upd;
        if (upd) begin
          pct_q <= advice.percent;
          log_q <= advice.log_ratio;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pmem_percent   = pct_q;
  assign out_o.log_ratio      = log_q;
  assign out_o.advice_updated = upd_q;

  // Held percent stays inside the clamp window
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pct_q >= PCT_W'(PCT_MIN)) && (pct_q <= PCT_W'(PCT_MAX)))
    else $error("advice percent outside clamp window");

  // An access in the current slot leaves the advice untouched
  a_same_slot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !change |=> !upd_q && (pct_q == $past(pct_q)) && (log_q == $past(log_q)))
    else $error("advice changed without a slot change");

  // Every advanced access produces a result beat
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && (cur_slot_q == $past(slot_q)))
    else $error("advanced access lost");

endmodule
`default_nettype wire

>>> design/rwra_slot_bank.sv
`timescale 1ns / 1ps
`default_nettype none
module rwra_slot_bank #(
  parameter int SLOT_COUNT = 4,
  parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rwra_pkg::bank_cmd_t         cmd_i,
  input  wire logic [SLOT_W-1:0]           slot_i,
  input  wire logic [rwra_pkg::LEN_W-1:0]  len_i,
  output rwra_pkg::cnt_t                   rd_cnt_o [SLOT_COUNT],
  output rwra_pkg::cnt_t                   wr_cnt_o [SLOT_COUNT]
);
  import rwra_pkg::*;

  cnt_t rd_cnt_q [SLOT_COUNT];
  cnt_t wr_cnt_q [SLOT_COUNT];
  cnt_t len_ext;

  assign len_ext = CNT_W'(len_i);

  // Clear the new slot on a slot change, then add the length to one counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rd_cnt_q[i] <= '0;
        wr_cnt_q[i] <= '0;
      end
    end else if (cmd_i.en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_i == SLOT_W'(i)) begin
          if (cmd_i.clear) begin
            rd_cnt_q[i] <= cmd_i.is_read ? len_ext : '0;
            wr_cnt_q[i] <= cmd_i.is_read ? '0 : len_ext;
          end else if (cmd_i.is_read) begin
            rd_cnt_q[i] <= sat_add(rd_cnt_q[i], len_ext);
          end else begin
            wr_cnt_q[i] <= sat_add(wr_cnt_q[i], len_ext);
          end
        end
      end
    end
  end

  assign rd_cnt_o = rd_cnt_q;
  assign wr_cnt_o = wr_cnt_q;

endmodule
`default_nettype wire

>>> design/rwra_advice.sv
`timescale 1ns / 1ps
`default_nettype none
module rwra_advice #(
  parameter int SLOT_COUNT = 4
) (
  input  wire rwra_pkg::cnt_t              rd_cnt_i [SLOT_COUNT],
  input  wire rwra_pkg::cnt_t              wr_cnt_i [SLOT_COUNT],
  input  wire logic [rwra_pkg::PCT_W-1:0]  base_i,
  output rwra_pkg::advice_t                advice_o
);
  import rwra_pkg::*;

  localparam int LEVELS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PAD    = 1 << LEVELS;

  cnt_t                    rd_lvl [LEVELS+1][PAD];
  cnt_t                    wr_lvl [LEVELS+1][PAD];
  logic [SLOT_COUNT-1:0]   empty;
  logic [LEAD_W-1:0]       lead_rd;
  logic [LEAD_W-1:0]       lead_wr;
  logic signed [LOG_W-1:0] diff;
  logic signed [PCT_SUM_W-1:0] diff_ext;
  logic signed [PCT_SUM_W-1:0] pct_sum;

  // Flag slots whose counters are both zero
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      empty[i] = (rd_cnt_i[i] == '0) && (wr_cnt_i[i] == '0);
    end
  end

  // Sum the slots through a saturating adder tree
  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      rd_lvl[0][i] = (i < SLOT_COUNT) ? rd_cnt_i[i] : '0;
      wr_lvl[0][i] = (i < SLOT_COUNT) ? wr_cnt_i[i] : '0;
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int i = 0; i < PAD; i++) begin
        if (i < (PAD >> l)) begin
          rd_lvl[l][i] = sat_add(rd_lvl[l-1][2*i], rd_lvl[l-1][2*i+1]);
          wr_lvl[l][i] = sat_add(wr_lvl[l-1][2*i], wr_lvl[l-1][2*i+1]);
        end else begin
          rd_lvl[l][i] = '0;
          wr_lvl[l][i] = '0;
        end
      end
    end
  end

  // Difference of leading-one positions and the clamped percent
  assign lead_rd  = lead_one(rd_lvl[LEVELS][0]);
  assign lead_wr  = lead_one(wr_lvl[LEVELS][0]);
  assign diff     = $signed({1'b0, lead_rd}) - $signed({1'b0, lead_wr});
  assign diff_ext = PCT_SUM_W'(diff);
  assign pct_sum  = $signed({{(PCT_SUM_W-PCT_W){1'b0}}, base_i})
                  + (diff_ext <<< 2) + diff_ext;

  always_comb begin
    advice_o.many_empty = |(empty & (empty - SLOT_COUNT'(1)));
    advice_o.log_ratio  = diff;
    if (pct_sum > $signed(PCT_SUM_W'(PCT_MAX))) begin
      advice_o.percent = PCT_W'(PCT_MAX);
    end else if (pct_sum < $signed(PCT_SUM_W'(PCT_MIN))) begin
      advice_o.percent = PCT_W'(PCT_MIN);
    end else begin
      advice_o.percent = pct_sum[PCT_W-1:0];
    end
  end

endmodule
`default_nettype wire
